### sv/sni_pkg.sv
// Shared types and constants for the SNI host name extractor.
// Used by sni_parse, sni_out_skid and the top level; no dependencies.
`timescale 1ns / 1ps

package sni_pkg;

    // Sizes of the extension body and of the name buffer
    localparam int NAME_BUFFER   = 256;
    localparam int MAX_EXT_BYTES = 65535;

    localparam int POS_W = 16;
    localparam int CAP_W = 9;

    // Capacity is clamped to the buffer size and to the 8-bit index range
    localparam int CAP_LIMIT_INT = (NAME_BUFFER < 256) ? NAME_BUFFER : 256;
    localparam logic [CAP_W-1:0] CAP_LIMIT   = CAP_W'(CAP_LIMIT_INT);
    localparam logic [CAP_W-1:0] CAP_RESET   = CAP_W'(256);
    localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_EXT_BYTES);

    // Header layout: list length (2 bytes), name type, name length (2 bytes)
    localparam logic [POS_W-1:0] POS_LIST_HI = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LIST_LO = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TYPE    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_NAME_HI = POS_W'(3);
    localparam logic [POS_W-1:0] POS_NAME_LO = POS_W'(4);
    localparam logic [POS_W-1:0] HDR_BYTES   = POS_W'(5);
    localparam logic [POS_W-1:0] MIN_LIST    = POS_W'(3);
    localparam logic [7:0]       CASE_GAP    = 8'd32;

    typedef enum logic [2:0] {
        RSN_OK,
        RSN_SHORT,
        RSN_LIST_LEN,
        RSN_NAME_TYPE,
        RSN_NAME_LEN,
        RSN_BAD_CHAR,
        RSN_LEAD_DOT
    } sni_reason_t;

    // One result beat
    typedef struct packed {
        logic [7:0]  host_length;
        sni_reason_t reject_reason;
        logic        accepted;
        logic        done_res;
        logic [7:0]  char_index;
        logic        char_valid;
        logic [7:0]  name_char;
    } sni_result_t;

    // Letters, digits, hyphen and dot after case folding
    function automatic logic is_dns_char(input logic [7:0] c);
        is_dns_char = (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
                      c == "-" || c == ".";
    endfunction

endpackage

### sv/sni_host_name_extractor_unit.sv
// Results: the result of each accepted beat is registered in sni_out_skid and shown at m_*.
// Throughput: one byte beat per cycle while s_tready is high; the skid entry in sni_out_skid
// takes a result beat while the result side stalls, and s_tready is low while it is full.
// Reset: aresetn is synchronous, active low; it clears the stream state and
// sets the name capacity to 256. There is no clearing pass.
`timescale 1ns / 1ps

module sni_host_name_extractor_unit import sni_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,      // name_capacity
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,        // [7:0] ext_byte
    input  logic              s_tlast,        // is_last
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [31:0]       m_tdata,        // [7:0] name_char, [15:8] char_index,
                                              // [16] accepted, [19:17] reject_reason,
                                              // [27:20] host_length, [31:28] zero
    output logic              m_tuser,        // char_valid
    output logic              m_tlast         // done_res
);

    logic        in_accept;
    sni_result_t res;
    sni_result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    sni_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .res       (res)
    );

    sni_out_skid u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (in_accept),
        .push_data  (res),
        .push_ready (s_tready),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_res)
    );

    // Pack the result beat
    assign m_tdata = {4'd0, out_res.host_length, out_res.reject_reason,
                      out_res.accepted, out_res.char_index, out_res.name_char};
    assign m_tuser = out_res.char_valid;
    assign m_tlast = out_res.done_res;

endmodule

### sv/sni_parse.sv
// Header parser, name byte folding and verdict logic for one input beat.
// Depends on sni_pkg; holds the per-extension state and the capacity register.
`timescale 1ns / 1ps

module sni_parse import sni_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_wdata,
    input  logic              in_accept,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output sni_result_t       res
);

    logic [CAP_W-1:0] cap_reg;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] list_len_reg, list_len_next;
    logic [POS_W-1:0] name_len_reg, name_len_next;
    logic             type_nz_reg, type_nz_next;
    logic             bad_reg, bad_next;
    logic             dot_reg, dot_next;

    logic             saturated;
    logic [POS_W-1:0] name_idx;
    logic             is_name;
    logic [7:0]       folded;
    logic [CAP_W-1:0] cap_eff;
    logic [POS_W:0]   list_end;
    logic [POS_W:0]   name_end;
    sni_reason_t      reason;

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

    assign cap_eff = (cap_reg > CAP_LIMIT) ? CAP_LIMIT : cap_reg;

    // Fold the byte and decide whether it lies in the name
    assign saturated = (pos_reg == POS_MAX);
    assign name_idx  = pos_reg - HDR_BYTES;
    assign is_name   = !saturated && (pos_reg >= HDR_BYTES) && (name_idx < name_len_reg);
    assign folded    = (in_byte >= "A" && in_byte <= "Z") ? in_byte + CASE_GAP : in_byte;

    // Update the header fields and flags with this beat
    always_comb begin
        pos_next      = saturated ? pos_reg : pos_reg + POS_W'(1);
        list_len_next = list_len_reg;
        name_len_next = name_len_reg;
        type_nz_next  = type_nz_reg;
        bad_next      = bad_reg;
        dot_next      = dot_reg;
        if (!saturated) begin
            unique case (pos_reg)
                POS_LIST_HI: list_len_next = {in_byte, list_len_reg[7:0]};
                POS_LIST_LO: list_len_next = {list_len_reg[15:8], in_byte};
                POS_TYPE:    type_nz_next  = (in_byte != 8'd0);
                POS_NAME_HI: name_len_next = {in_byte, name_len_reg[7:0]};
                POS_NAME_LO: name_len_next = {name_len_reg[15:8], in_byte};
                default: begin
                    if (is_name) begin
                        if (!is_dns_char(folded)) bad_next = 1'b1;
                        if (name_idx == '0 && folded == ".") dot_next = 1'b1;
                    end
                end
            endcase
        end
    end

    // Verdict on the updated state, total length being the new count
    assign list_end = {1'b0, list_len_next} + (POS_W+1)'(2);
    assign name_end = {1'b0, name_len_next} + {1'b0, HDR_BYTES};

    always_comb begin
        priority if (pos_next < HDR_BYTES) begin
            reason = RSN_SHORT;
        end else if (list_end > {1'b0, pos_next} || list_len_next < MIN_LIST) begin
            reason = RSN_LIST_LEN;
        end else if (type_nz_next) begin
            reason = RSN_NAME_TYPE;
        end else if (name_len_next == '0 || name_end > {1'b0, pos_next} ||
                     name_len_next >= POS_W'(cap_eff)) begin
            reason = RSN_NAME_LEN;
        end else if (bad_next) begin
            reason = RSN_BAD_CHAR;
        end else if (dot_next) begin
            reason = RSN_LEAD_DOT;
        end else begin
            reason = RSN_OK;
        end
    end

    // Assemble the result beat
    always_comb begin
        res               = '0;
        res.reject_reason = RSN_OK;
        if (is_name && name_idx[POS_W-1:8] == '0) begin
            res.name_char  = folded;
            res.char_valid = 1'b1;
            res.char_index = name_idx[7:0];
        end
        if (in_last) begin
            res.done_res      = 1'b1;
            res.reject_reason = reason;
            res.accepted      = (reason == RSN_OK);
            res.host_length   = (reason == RSN_OK) ? name_len_next[7:0] : 8'd0;
        end
    end

    // State registers; drop the stream state after the last beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            list_len_reg <= '0;
            name_len_reg <= '0;
            type_nz_reg  <= 1'b0;
            bad_reg      <= 1'b0;
            dot_reg      <= 1'b0;
        end else if (in_accept) begin
            if (in_last) begin
                pos_reg      <= '0;
                list_len_reg <= '0;
                name_len_reg <= '0;
                type_nz_reg  <= 1'b0;
                bad_reg      <= 1'b0;
                dot_reg      <= 1'b0;
            end else begin
                pos_reg      <= pos_next;
                list_len_reg <= list_len_next;
                name_len_reg <= name_len_next;
                type_nz_reg  <= type_nz_next;
                bad_reg      <= bad_next;
                dot_reg      <= dot_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && in_last |=> pos_reg == '0 && !type_nz_reg && !bad_reg && !dot_reg)
        else $error("stream state not cleared after last beat");

    a_count_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && !in_last && pos_reg != POS_MAX |=> pos_reg == $past(pos_reg) + POS_W'(1))
        else $error("byte counter did not advance");

    a_accept_has_length: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && res.accepted |-> res.done_res && res.host_length != 8'd0)
        else $error("accepted verdict without host length");
`endif

endmodule

### sv/sni_out_skid.sv
// Output register with one skid entry for result beats.
// Depends on sni_pkg for the result struct.
`timescale 1ns / 1ps

module sni_out_skid import sni_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  sni_result_t push_data,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output sni_result_t out_data
);

    logic        main_valid_reg;
    logic        skid_valid_reg;
    sni_result_t main_reg;
    sni_result_t skid_reg;
    logic        pop;

    assign pop        = main_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;

    // Control: refill main from skid first, else from the new beat; park the new beat in skid while main is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!main_valid_reg || pop) begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end else if (push) begin
            skid_reg <= push_data;
        end
    end

endmodule

### test/sni_host_name_extractor_unit_test.sv
// Self-checking testbench for sni_host_name_extractor_unit: SNI extension bodies,
// directed and random, with a predictor in step with the stream and random stalls.
// Depends on sni_pkg and the RTL of the top level; reads no files.
`timescale 1ns / 1ps

module sni_host_name_extractor_unit_test;
    import sni_pkg::*;

    // One result beat, as predicted or as seen on m_*
    typedef struct packed {
        logic [7:0]  name_char;
        logic        char_valid;
        logic [7:0]  char_index;
        logic        done_res;
        logic        accepted;
        sni_reason_t reject_reason;
        logic [7:0]  host_length;
    } host_beat_t;

    // One row of the directed table; want is used only when typed is set
    typedef struct {
        logic [7:0] ext_byte;
        logic       is_last;
        bit         typed;
        host_beat_t want;
    } dir_row_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = 8'h00;    // [7:0] ext_byte
    logic             s_tlast   = 1'b0;     // is_last
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [31:0]      m_tdata;              // [7:0] name_char, [15:8] char_index,
                                            // [16] accepted, [19:17] reject_reason,
                                            // [27:20] host_length, [31:28] zero
    logic             m_tuser;              // char_valid
    logic             m_tlast;              // done_res

    // Predictor state: stream position, header fields, flags and capacity
    logic [POS_W-1:0] ext_pos;
    logic [15:0]      hdr_list_len;
    logic [15:0]      hdr_name_len;
    logic             kind_nonzero;
    logic             bad_seen;
    logic             lead_dot;
    logic [CAP_W-1:0] host_cap;

    host_beat_t host_q[$];
    dir_row_t   dir_rows[$];
    host_beat_t got;
    host_beat_t want;
    bit         no_gaps = 1'b0;
    int         mismatches = 0;
    int         beats_sent = 0;
    int         results_seen = 0;
    int         bodies_done = 0;
    int         names_ok = 0;
    int         caps_written = 0;

    sni_host_name_extractor_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Hard limit on the run
    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic bit take_gap();
        return !no_gaps && ($urandom_range(99) < 23);
    endfunction

    function automatic int cap_eff();
        return (host_cap > CAP_LIMIT) ? int'(CAP_LIMIT) : int'(host_cap);
    endfunction

    // Advance the predictor by one byte and return the result it causes
    function automatic host_beat_t extract_step(input logic [7:0] b, input logic l);
        host_beat_t r;
        logic [7:0] c;
        int         i;
        int         total;
        r = '0;
        if (ext_pos != POS_MAX) begin
            i = int'(ext_pos) - int'(HDR_BYTES);
            if (ext_pos == POS_LIST_HI) begin
                hdr_list_len[15:8] = b;
            end else if (ext_pos == POS_LIST_LO) begin
                hdr_list_len[7:0] = b;
            end else if (ext_pos == POS_TYPE) begin
                kind_nonzero = (b != 8'h00);
            end else if (ext_pos == POS_NAME_HI) begin
                hdr_name_len[15:8] = b;
            end else if (ext_pos == POS_NAME_LO) begin
                hdr_name_len[7:0] = b;
            end else if (i < int'(hdr_name_len)) begin
                // fold upper case, then flag anything outside the host name alphabet
                c = (b >= "A" && b <= "Z") ? b + CASE_GAP : b;
                if (!((c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
                      c == "-" || c == "."))
                    bad_seen = 1'b1;
                if (i == 0 && c == ".")
                    lead_dot = 1'b1;
                if (i < 256) begin
                    r.name_char  = c;
                    r.char_valid = 1'b1;
                    r.char_index = i[7:0];
                end
            end
            ext_pos = ext_pos + POS_W'(1);
        end
        if (l) begin
            total = int'(ext_pos);
            r.done_res = 1'b1;
            if (total < int'(HDR_BYTES))
                r.reject_reason = RSN_SHORT;
            else if (int'(hdr_list_len) + 2 > total || hdr_list_len < MIN_LIST)
                r.reject_reason = RSN_LIST_LEN;
            else if (kind_nonzero)
                r.reject_reason = RSN_NAME_TYPE;
            else if (hdr_name_len == '0 || int'(hdr_name_len) + int'(HDR_BYTES) > total ||
                     int'(hdr_name_len) >= cap_eff())
                r.reject_reason = RSN_NAME_LEN;
            else if (bad_seen)
                r.reject_reason = RSN_BAD_CHAR;
            else if (lead_dot)
                r.reject_reason = RSN_LEAD_DOT;
            else begin
                r.reject_reason = RSN_OK;
                r.accepted      = 1'b1;
                r.host_length   = hdr_name_len[7:0];
            end
            ext_pos      = '0;
            hdr_list_len = '0;
            hdr_name_len = '0;
            kind_nonzero = 1'b0;
            bad_seen     = 1'b0;
            lead_dot     = 1'b0;
        end
        return r;
    endfunction

    // Verdict beat for a one-byte name at index 0 (or none), as typed in the table
    function automatic host_beat_t verdict_beat(input logic [7:0] c, input logic v,
                                                input sni_reason_t why,
                                                input logic [7:0] hlen);
        host_beat_t r;
        r               = '0;
        r.name_char     = c;
        r.char_valid    = v;
        r.done_res      = 1'b1;
        r.accepted      = (why == RSN_OK);
        r.reject_reason = why;
        r.host_length   = hlen;
        return r;
    endfunction

    function automatic logic [7:0] host_char();
        case ($urandom_range(3))
            0:       return 8'("a" + $urandom_range(25));
            1:       return 8'("A" + $urandom_range(25));
            2:       return 8'("0" + $urandom_range(9));
            default: return $urandom_range(1) ? "-" : ".";
        endcase
    endfunction

    task automatic add_row(input logic [7:0] b, input logic l, input bit typed,
                           input host_beat_t w);
        dir_row_t row;
        row.ext_byte = b;
        row.is_last  = l;
        row.typed    = typed;
        row.want     = w;
        dir_rows.push_back(row);
    endtask

    task automatic add_hdr(input logic [15:0] list, input logic [7:0] kind,
                           input logic [15:0] nlen);
        add_row(list[15:8], 1'b0, 1'b0, '0);
        add_row(list[7:0],  1'b0, 1'b0, '0);
        add_row(kind,       1'b0, 1'b0, '0);
        add_row(nlen[15:8], 1'b0, 1'b0, '0);
        add_row(nlen[7:0],  1'b0, 1'b0, '0);
    endtask

    // Drive one byte beat at the falling edge, hold it until accepted, record the
    // expected result. Returns at the next falling edge with s_tvalid still high.
    task automatic push_beat(input logic [7:0] b, input logic l, input bit typed,
                             input host_beat_t w);
        host_beat_t pred;
        while (take_gap()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pred = extract_step(b, l);
        host_q.push_back(typed ? w : pred);
        beats_sent++;
        if (pred.done_res) begin
            bodies_done++;
            if (pred.accepted) names_ok++;
        end
        @(negedge aclk);
    endtask

    // Drain the result side, then write the capacity register while idle
    task automatic write_capacity(input logic [CAP_W-1:0] v);
        s_tvalid <= 1'b0;
        while (host_q.size() != 0) @(posedge aclk);
        repeat (2) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we   <= 1'b0;
        host_cap  = v;
        caps_written++;
    endtask

    // One extension body with an n-byte name; with mess set, corrupt it at random
    task automatic send_ext(input int n, input bit mess);
        logic [7:0]  body[$];
        logic [15:0] list;
        logic [15:0] nlen;
        logic [7:0]  kind;
        logic [7:0]  c;
        int          r;
        int          i;
        int          cut;
        list = 16'(n + 3);
        nlen = 16'(n);
        kind = 8'h00;
        if (mess) begin
            r = $urandom_range(99);
            if (r < 6) list = 16'($urandom);
            else if (r < 12) list = 16'($urandom_range(0, 4));
            if ($urandom_range(99) < 8) kind = 8'($urandom_range(1, 255));
        end
        body.push_back(list[15:8]);
        body.push_back(list[7:0]);
        body.push_back(kind);
        body.push_back(nlen[15:8]);
        body.push_back(nlen[7:0]);
        for (i = 0; i < n; i++) begin
            c = host_char();
            if (mess) begin
                r = $urandom_range(99);
                if (r < 5) c = 8'($urandom);
                else if (i == 0 && r < 10) c = ".";
            end
            body.push_back(c);
        end
        // trailing bytes past the name, or an early end
        if (mess && $urandom_range(99) < 20)
            repeat ($urandom_range(1, 3)) body.push_back(8'($urandom));
        if (mess && $urandom_range(99) < 8) begin
            cut = $urandom_range(1, body.size() - 1);
            while (body.size() > cut) void'(body.pop_back());
        end
        for (i = 0; i < body.size(); i++)
            push_beat(body[i], i == body.size() - 1, 1'b0, '0);
    endtask

    // Mostly well-formed bodies, some plain noise
    task automatic run_random(input int n_beats);
        int start;
        int n;
        int r;
        start = beats_sent;
        while (beats_sent - start < n_beats) begin
            if ($urandom_range(99) < 15) begin
                n = $urandom_range(1, 8);
                for (r = 0; r < n; r++)
                    push_beat(8'($urandom), r == n - 1, 1'b0, '0);
            end else begin
                r = $urandom_range(99);
                if (r < 70) n = $urandom_range(1, 12);
                else if (r < 80 && cap_eff() <= 64) n = cap_eff() - int'($urandom_range(0, 1));
                else if (r < 90) n = 0;
                else n = $urandom_range(13, 40);
                if (n < 0) n = 0;
                send_ext(n, 1'b1);
            end
        end
    endtask

    task automatic check_field(input string what, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Result side: random stalls, with a long stretch held ready
    always @(negedge aclk) begin
        m_tready <= !take_gap();
    end

    // Compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got.name_char     = m_tdata[7:0];
            got.char_index    = m_tdata[15:8];
            got.accepted      = m_tdata[16];
            got.reject_reason = sni_reason_t'(m_tdata[19:17]);
            got.host_length   = m_tdata[27:20];
            got.char_valid    = m_tuser;
            got.done_res      = m_tlast;
            results_seen++;
            if (host_q.size() == 0) begin
                $display("%0t ns: result beat with nothing expected, got %h", $time, got);
                mismatches++;
            end else begin
                want = host_q.pop_front();
                check_field("name_char",     want.name_char,         got.name_char);
                check_field("char_valid",    8'(want.char_valid),    8'(got.char_valid));
                check_field("char_index",    want.char_index,        got.char_index);
                check_field("done_res",      8'(want.done_res),      8'(got.done_res));
                check_field("accepted",      8'(want.accepted),      8'(got.accepted));
                check_field("reject_reason", 8'(want.reject_reason), 8'(got.reject_reason));
                check_field("host_length",   want.host_length,       got.host_length);
            end
        end
    end

    initial begin
        ext_pos      = '0;
        hdr_list_len = '0;
        hdr_name_len = '0;
        kind_nonzero = 1'b0;
        bad_seen     = 1'b0;
        lead_dot     = 1'b0;
        host_cap     = CAP_RESET;

        // Directed table: short body, list length overflow with all-ones bytes,
        // nonzero name type, leading dot, and one good name with case folding
        add_row(8'h00, 1'b1, 1'b1, verdict_beat(8'h00, 1'b0, RSN_SHORT, 8'd0));
        add_hdr(16'hFFFF, 8'hFF, 16'hFF00);
        add_row(8'hFF, 1'b1, 1'b1, verdict_beat(8'hFF, 1'b1, RSN_LIST_LEN, 8'd0));
        add_hdr(16'd3, 8'h80, 16'd1);
        add_row("x", 1'b1, 1'b1, verdict_beat("x", 1'b1, RSN_NAME_TYPE, 8'd0));
        add_hdr(16'd3, 8'h00, 16'd1);
        add_row(".", 1'b1, 1'b1, verdict_beat(".", 1'b1, RSN_LEAD_DOT, 8'd0));
        add_hdr(16'd3, 8'h00, 16'd1);
        add_row("Z", 1'b1, 1'b1, verdict_beat("z", 1'b1, RSN_OK, 8'd1));

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[k])
            push_beat(dir_rows[k].ext_byte, dir_rows[k].is_last, dir_rows[k].typed,
                      dir_rows[k].want);

        // Random bodies under a range of capacities, the extremes among them
        write_capacity(9'd1);
        run_random(30);
        write_capacity(9'd0);
        run_random(30);
        write_capacity(9'd511);
        no_gaps = 1'b1;
        run_random(30);
        // a name with bytes past index 255, sent without stalls
        send_ext(257, 1'b0);
        no_gaps = 1'b0;
        write_capacity(9'd257);
        run_random(30);
        write_capacity(9'($urandom_range(2, 64)));
        run_random(30);
        write_capacity(CAP_RESET);
        run_random(30);
        s_tvalid <= 1'b0;

        while (host_q.size() != 0) @(posedge aclk);
        repeat (5) @(posedge aclk);

        $display("Sent %0d byte beats in %0d extension bodies, %0d names accepted, %0d checked",
                 beats_sent, bodies_done, names_ok, results_seen);
        $display("Capacity written %0d times (0, 1, 257, 511 among them); one name ran past 255",
                 caps_written);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
